[src/cspg_pkg.sv]
package cspg_pkg;

  localparam int MAX_LEVEL = 8;
  localparam int FRAC_BITS = 20;

  localparam int LEVEL_W  = 4;
  localparam int RADIUS_W = 23;
  localparam int INDEX_W  = 19;
  localparam int COORD_W  = 24;
  localparam int LANES    = 3;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = RADIUS_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(64'd3 << (FRAC_BITS - 1));

  // k div 6 as (k * DIV6_MUL) >> DIV6_SHIFT, exact for every 19-bit k
  localparam int DIV6_MUL   = 174763;
  localparam int DIV6_W     = 18;
  localparam int DIV6_SHIFT = 20;

  localparam int LV_W  = $clog2(MAX_LEVEL + 1);
  localparam int M_W   = MAX_LEVEL + 1;
  localparam int S_W   = 2 * MAX_LEVEL + 2;
  localparam int RM_W  = RADIUS_W + MAX_LEVEL;
  localparam int SQ_W  = 2 * RM_W;
  localparam int X_W   = SQ_W + 2;

  localparam int MAG_BITS = 24;
  localparam int YS_W     = MAG_BITS + 1 + S_W + 1;
  localparam int R_W      = YS_W + MAG_BITS + 2;

  localparam int DEC_STAGES  = 4;
  localparam int ROOT_STAGES = MAG_BITS + 1;
  localparam int PIPE_STAGES = DEC_STAGES + ROOT_STAGES + 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LEVEL  = CFG_ADDR_W'(0),
    REG_RADIUS = CFG_ADDR_W'(1)
  } cfg_reg_t;

  typedef struct packed {
    logic [LANES-1:0][X_W-1:0] x_sq;
    logic [S_W-1:0]            s;
    logic [LANES-1:0]          neg;
    logic                      err;
  } geom_t;

  typedef struct packed {
    logic [LANES-1:0][MAG_BITS-1:0] mag;
    logic [LANES-1:0]               neg;
    logic                           err;
  } root_res_t;

  typedef struct packed {
    logic [PIPE_STAGES-1:0] en;
    logic                   in_ready;
    logic                   out_valid;
  } flow_t;

endpackage

[src/cspg_intf.sv]
interface cspg_index_if;
  import cspg_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] point_index;
  modport source (output valid, point_index, input ready);
  modport sink (input valid, point_index, output ready);
endinterface

interface cspg_point_if;
  import cspg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] z_coord;
  logic                      index_error;
  modport source (output valid, x_coord, y_coord, z_coord, index_error, input ready);
  modport sink (input valid, x_coord, y_coord, z_coord, index_error, output ready);
endinterface

interface cspg_cfg_if;
  import cspg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/cspg_flow.sv]
module cspg_flow (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_ready,
  output cspg_pkg::flow_t flow
);
  import cspg_pkg::*;

  logic [PIPE_STAGES-1:0] v;
  logic [PIPE_STAGES-1:0] v_next;
  logic [PIPE_STAGES-1:0] en;

  // a stage may load when it or any stage after it is empty, or the sink takes the word
  always_comb begin
    logic [PIPE_STAGES-1:0] mask;
    for (int k = 0; k < PIPE_STAGES; k++) begin
      mask  = (PIPE_STAGES'(1) << k) - PIPE_STAGES'(1);
      en[k] = out_ready || ((v | mask) != '1);
    end
  end

  always_comb begin
    logic [PIPE_STAGES-1:0] shifted;
    shifted = {v[PIPE_STAGES-2:0], in_valid};
    for (int k = 0; k < PIPE_STAGES; k++) begin
      v_next[k] = en[k] ? shifted[k] : v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  assign flow.en        = en;
  assign flow.in_ready  = en[0] && !rst;
  assign flow.out_valid = v[PIPE_STAGES-1];

`ifndef SYNTHESIS
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !flow.in_ready |-> (&v) && !out_ready)
    else $error("input stalled with a free stage");
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(v) == $past($countones(v)) + int'($past(in_valid && flow.in_ready))
                              - int'($past(flow.out_valid && out_ready)))
    else $error("pipeline word count mismatch");
`endif

endmodule

[src/cspg_decode.sv]
module cspg_decode (
  input  logic                               clk,
  input  logic [cspg_pkg::DEC_STAGES-1:0]    en,
  input  logic [cspg_pkg::LV_W-1:0]          lv,
  input  logic [cspg_pkg::RADIUS_W-1:0]      radius,
  input  logic [cspg_pkg::INDEX_W-1:0]       point_index,
  output cspg_pkg::geom_t                    geom
);
  import cspg_pkg::*;

  localparam int PROD_W = INDEX_W + DIV6_W;
  localparam int TILE_W = PROD_W - DIV6_SHIFT;
  localparam int LIM_W  = 2 * MAX_LEVEL + 3;
  localparam int CMP_W  = (INDEX_W > LIM_W) ? INDEX_W : LIM_W;

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

  logic [INDEX_W-1:0] k1;
  logic [PROD_W-1:0]  prod1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k1    <= point_index;
      prod1 <= PROD_W'(point_index) * PROD_W'(DIV6_MUL);
    end
  end

  logic [TILE_W-1:0]         tile;
  logic [INDEX_W-1:0]        six_tile;
  logic [2:0]                face;
  logic [M_W-1:0]            n;
  logic [M_W-2:0]            ci;
  logic [M_W-2:0]            cj;
  logic signed [M_W:0]       u;
  logic signed [M_W:0]       v;
  logic [M_W-1:0]            u_mag;
  logic [M_W-1:0]            v_mag;
  logic [LIM_W-1:0]          lim;
  logic                      err;
  logic [LANES-1:0][M_W-1:0] mag;
  logic [LANES-1:0]          neg;

  always_comb begin
    tile     = prod1[PROD_W-1:DIV6_SHIFT];
    six_tile = INDEX_W'({tile, 2'b00}) + INDEX_W'({tile, 1'b0});
    face     = 3'(k1 - six_tile);
    n        = M_W'(1) << lv;
    ci       = (M_W-1)'(tile >> lv);
    cj       = (M_W-1)'(tile) & (M_W-1)'(n - M_W'(1));
    u        = $signed({1'b0, ci, 1'b1}) - $signed({1'b0, n});
    v        = $signed({1'b0, cj, 1'b1}) - $signed({1'b0, n});
    u_mag    = u[M_W] ? M_W'(-u) : M_W'(u);
    v_mag    = v[M_W] ? M_W'(-v) : M_W'(v);
    lim      = LIM_W'(3) << {lv, 1'b1};
    err      = CMP_W'(k1) >= CMP_W'(lim);
    unique case (axis_t'(face[2:1]))
      AXIS_X: begin
        mag = {v_mag, u_mag, n};
        neg = {v[M_W], u[M_W], face[0]};
      end
      AXIS_Y: begin
        mag = {v_mag, n, u_mag};
        neg = {v[M_W], face[0], u[M_W]};
      end
      AXIS_Z: begin
        mag = {n, v_mag, u_mag};
        neg = {face[0], v[M_W], u[M_W]};
      end
      default: begin
        mag = {n, v_mag, u_mag};
        neg = {face[0], v[M_W], u[M_W]};
      end
    endcase
  end

  logic [LANES-1:0][M_W-1:0] mag2;
  logic [LANES-1:0]          neg2;
  logic                      err2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mag2 <= mag;
      neg2 <= neg;
      err2 <= err;
    end
  end

  logic [S_W-1:0]             s3;
  logic [LANES-1:0][RM_W-1:0] rm3;
  logic [LANES-1:0]           neg3;
  logic                       err3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3 <= S_W'(mag2[0]) * S_W'(mag2[0]) + S_W'(mag2[1]) * S_W'(mag2[1])
          + S_W'(mag2[2]) * S_W'(mag2[2]);
      for (int ln = 0; ln < LANES; ln++) begin
        rm3[ln] <= RM_W'(radius) * RM_W'(mag2[ln]);
      end
      neg3 <= neg2;
      err3 <= err2;
    end
  end

  logic [S_W-1:0]             s4;
  logic [LANES-1:0][SQ_W-1:0] sq4;
  logic [LANES-1:0]           neg4;
  logic                       err4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int ln = 0; ln < LANES; ln++) begin
        sq4[ln] <= SQ_W'(rm3[ln]) * SQ_W'(rm3[ln]);
      end
      s4   <= s3;
      neg4 <= neg3;
      err4 <= err3;
    end
  end

  always_comb begin
    for (int ln = 0; ln < LANES; ln++) begin
      geom.x_sq[ln] = {sq4[ln], 2'b00};
    end
    geom.s   = s4;
    geom.neg = neg4;
    geom.err = err4;
  end

endmodule

[src/cspg_root.sv]
module cspg_root (
  input  logic                               clk,
  input  logic [cspg_pkg::ROOT_STAGES-1:0]   en,
  input  cspg_pkg::geom_t                    geom,
  output cspg_pkg::root_res_t                res
);
  import cspg_pkg::*;

  // per lane: largest t with (2t-1)^2 * s <= x_sq, one bit of t per stage
  logic signed [R_W-1:0]  rem  [0:MAG_BITS-1][0:LANES-1];
  logic signed [YS_W-1:0] ys   [0:MAG_BITS-1][0:LANES-1];
  logic [MAG_BITS-1:0]    tq   [1:MAG_BITS][0:LANES-1];
  logic [S_W-1:0]         s_q  [0:MAG_BITS-1];
  logic [LANES-1:0]       neg_q [0:MAG_BITS];
  logic                   err_q [0:MAG_BITS];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int ln = 0; ln < LANES; ln++) begin
        rem[0][ln] <= $signed(R_W'(geom.x_sq[ln])) - $signed(R_W'(geom.s));
        ys[0][ln]  <= -$signed(YS_W'(geom.s));
      end
      s_q[0]   <= geom.s;
      neg_q[0] <= geom.neg;
      err_q[0] <= geom.err;
    end
  end

  for (genvar gi = 1; gi <= MAG_BITS; gi++) begin : g_stage
    localparam int B = MAG_BITS - gi;

    logic signed [R_W-1:0] cand   [0:LANES-1];
    logic [LANES-1:0]      take;
    logic [MAG_BITS-1:0]   t_prev [0:LANES-1];

    if (gi == 1) begin : g_first
      always_comb begin
        for (int ln = 0; ln < LANES; ln++) begin
          t_prev[ln] = '0;
        end
      end
    end else begin : g_rest
      always_comb begin
        for (int ln = 0; ln < LANES; ln++) begin
          t_prev[ln] = tq[gi-1][ln];
        end
      end
    end

    always_comb begin
      for (int ln = 0; ln < LANES; ln++) begin
        cand[ln] = rem[gi-1][ln] - (R_W'(ys[gi-1][ln]) <<< (B + 2))
                 - ($signed(R_W'(s_q[gi-1])) <<< (2 * B + 2));
        take[ln] = !cand[ln][R_W-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[gi]) begin
        for (int ln = 0; ln < LANES; ln++) begin
          tq[gi][ln] <= t_prev[ln] | (MAG_BITS'(take[ln]) << B);
        end
        neg_q[gi] <= neg_q[gi-1];
        err_q[gi] <= err_q[gi-1];
      end
    end

    if (gi < MAG_BITS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[gi]) begin
          for (int ln = 0; ln < LANES; ln++) begin
            rem[gi][ln] <= take[ln] ? cand[ln] : rem[gi-1][ln];
            ys[gi][ln]  <= take[ln]
                         ? ys[gi-1][ln] + $signed(YS_W'(s_q[gi-1]) << (B + 1))
                         : ys[gi-1][ln];
          end
          s_q[gi] <= s_q[gi-1];
        end
      end
    end
  end

  always_comb begin
    for (int ln = 0; ln < LANES; ln++) begin
      res.mag[ln] = tq[MAG_BITS][ln];
    end
    res.neg = neg_q[MAG_BITS];
    res.err = err_q[MAG_BITS];
  end

endmodule

[src/cube_sphere_point_generator_unit.sv]
// channel  modport  word                                          accepted when
// idx      sink     point_index                                   idx.valid && idx.ready
// pnt      source   x_coord, y_coord, z_coord, index_error        pnt.valid && pnt.ready
// cfg      sink     index (0 level, 1 radius), data               cfg.valid && cfg.ready
//
// One point per cycle while pnt is not stalled; a result reaches pnt after its index is taken,
// passing through 4 decode/multiply stages, 25 square-root search stages and the output register.
// rst (synchronous) empties the pipeline and sets level 0, radius 1.5; cfg.ready is always high.
// A stalled pnt holds its word; stages behind it keep filling bubbles, and idx.ready
// drops only when all 30 stages hold a word and pnt is not taken, or while rst is high.
module cube_sphere_point_generator_unit (
  input logic          clk,
  input logic          rst,
  cspg_index_if.sink   idx,
  cspg_point_if.source pnt,
  cspg_cfg_if.sink     cfg
);
  import cspg_pkg::*;

  logic [LEVEL_W-1:0]  level;
  logic [RADIUS_W-1:0] radius;
  logic [LV_W-1:0]     lv;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      radius <= RADIUS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_LEVEL:  level  <= cfg.data[LEVEL_W-1:0];
        REG_RADIUS: radius <= cfg.data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate level at the deepest grid
  assign lv = (level > LEVEL_W'(MAX_LEVEL)) ? LV_W'(MAX_LEVEL) : LV_W'(level);

  flow_t     flow;
  geom_t     geom;
  root_res_t rr;

  cspg_flow u_flow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (idx.valid),
    .out_ready (pnt.ready),
    .flow      (flow)
  );

  assign idx.ready = flow.in_ready;
  assign pnt.valid = flow.out_valid;

  cspg_decode u_decode (
    .clk         (clk),
    .en          (flow.en[DEC_STAGES-1:0]),
    .lv          (lv),
    .radius      (radius),
    .point_index (idx.point_index),
    .geom        (geom)
  );

  cspg_root u_root (
    .clk  (clk),
    .en   (flow.en[DEC_STAGES +: ROOT_STAGES]),
    .geom (geom),
    .res  (rr)
  );

  logic signed [COORD_W-1:0] coord [0:LANES-1];

  always_comb begin
    for (int ln = 0; ln < LANES; ln++) begin
      if (rr.err) begin
        coord[ln] = '0;
      end else if (rr.neg[ln]) begin
        coord[ln] = -$signed(COORD_W'(rr.mag[ln]));
      end else begin
        coord[ln] = $signed(COORD_W'(rr.mag[ln]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flow.en[PIPE_STAGES-1]) begin
      pnt.x_coord     <= coord[0];
      pnt.y_coord     <= coord[1];
      pnt.z_coord     <= coord[2];
      pnt.index_error <= rr.err;
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    pnt.valid && pnt.index_error |->
      pnt.x_coord == '0 && pnt.y_coord == '0 && pnt.z_coord == '0)
    else $error("index error word with nonzero coordinates");
  a_x_bound: assert property (@(posedge clk) disable iff (rst)
    pnt.valid |->
      (pnt.x_coord[COORD_W-1] ? COORD_W'(-pnt.x_coord) : COORD_W'(pnt.x_coord))
        <= COORD_W'(radius))
    else $error("x coordinate beyond radius");
`endif

endmodule
